FILE: rtl/core/rrtss_pkg.sv
`timescale 1ns / 1ps

package rrtss_pkg;

    localparam int KIND_W    = 3;
    localparam int ID_W      = 5;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;

    localparam logic [KIND_W-1:0] KIND_CREATE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_YIELD  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PREV   = 3'd4;

    localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STS_BAD_ID  = 2'd2;
    localparam logic [STATUS_W-1:0] STS_NO_TASK = 2'd3;

    typedef enum logic [1:0] {
        SCAN_CREATE,
        SCAN_NEXT_QUIET,
        SCAN_NEXT,
        SCAN_PREV
    } scan_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic start;
        logic step;
        logic resolve_hit;
        logic resolve_miss;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic hit;
        logic exhausted;
    } dp_sts_t;

endpackage

FILE: rtl/core/rrtss_ctrl.sv
`timescale 1ns / 1ps

module rrtss_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  rrtss_pkg::dp_sts_t sts,
    output rrtss_pkg::dp_cmd_t cmd
);
    import rrtss_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = sts.need_scan ? ST_SCAN : ST_RESP;
                end
            end
            ST_SCAN:
            begin
                if (sts.exhausted || sts.hit)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.emit)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.start = s_tvalid;
            end
            ST_SCAN:
            begin
                if (sts.exhausted)
                begin
                    cmd.resolve_miss = 1'b1;
                end
                else if (sts.hit)
                begin
                    cmd.resolve_hit = 1'b1;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_RESP:
            begin
                cmd.emit = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: rtl/core/rrtss_datapath.sv
`timescale 1ns / 1ps

module rrtss_datapath
#(
    parameter int MAX_TASKS = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  rrtss_pkg::dp_cmd_t             cmd,
    output rrtss_pkg::dp_sts_t             sts,
    input  logic [rrtss_pkg::KIND_W-1:0]   kind,
    input  logic [rrtss_pkg::ID_W-1:0]     task_id,
    output logic [rrtss_pkg::STATUS_W-1:0] status,
    output logic [rrtss_pkg::ID_W-1:0]     assigned_id,
    output logic [rrtss_pkg::ID_W-1:0]     current_task,
    output logic [rrtss_pkg::ID_W-1:0]     previous_task,
    output logic                           switched
);
    import rrtss_pkg::*;

    localparam int IW = $clog2(MAX_TASKS);
    localparam int HW = $clog2(MAX_TASKS + 1);
    localparam int CW = (HW > ID_W) ? HW : ID_W;

    // architectural state
    logic [MAX_TASKS-1:0] used_reg, used_next;
    logic [HW-1:0]        hw_reg, hw_next;
    logic [IW-1:0]        run_reg, run_next;
    logic                 flag_reg, flag_next;

    // scan and item state
    scan_mode_t           mode_reg, mode_next;
    logic [IW-1:0]        cand_reg, cand_next;
    logic [HW-1:0]        left_reg, left_next;
    logic [IW-1:0]        before_reg, before_next;
    logic [STATUS_W-1:0]  res_sts_reg, res_sts_next;
    logic [IW-1:0]        asg_reg, asg_next;

    // output item
    logic [STATUS_W-1:0]  o_sts_reg, o_sts_next;
    logic [ID_W-1:0]      o_asg_reg, o_asg_next;
    logic [ID_W-1:0]      o_cur_reg, o_cur_next;
    logic [ID_W-1:0]      o_prev_reg, o_prev_next;
    logic                 o_sw_reg, o_sw_next;

    logic [CW-1:0]        id_ext;
    logic                 id_bad;
    logic [IW-1:0]        id_slot;
    logic [CW-1:0]        asg_ext, run_ext, before_ext;

    function automatic logic [IW-1:0] slot_up(input logic [IW-1:0] p, input logic [HW-1:0] hw);
        logic [CW-1:0] inc;
        inc = CW'(p) + CW'(1);
        if (inc == CW'(hw))
        begin
            return '0;
        end
        return inc[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] slot_dn(input logic [IW-1:0] p, input logic [HW-1:0] hw);
        logic [HW-1:0] top;
        top = hw - HW'(1);
        if (p == '0)
        begin
            return top[IW-1:0];
        end
        return p - IW'(1);
    endfunction

    assign id_ext  = CW'(task_id);
    assign id_bad  = (task_id == '0) || (id_ext >= CW'(hw_reg));
    assign id_slot = id_ext[IW-1:0];

    assign asg_ext    = CW'(asg_reg);
    assign run_ext    = CW'(run_reg);
    assign before_ext = CW'(before_reg);

    always_comb
    begin
        unique case (kind)
            KIND_CREATE: sts.need_scan = 1'b1;
            KIND_REMOVE: sts.need_scan = !id_bad;
            KIND_TICK:   sts.need_scan = !flag_reg;
            KIND_YIELD:  sts.need_scan = 1'b1;
            KIND_PREV:   sts.need_scan = 1'b1;
            default:     sts.need_scan = 1'b0;
        endcase
        sts.exhausted = (left_reg == '0);
        if (mode_reg == SCAN_CREATE)
        begin
            sts.hit = !sts.exhausted && !used_reg[cand_reg];
        end
        else
        begin
            sts.hit = !sts.exhausted && used_reg[cand_reg];
        end
    end

    always_comb
    begin
        used_next    = used_reg;
        hw_next      = hw_reg;
        run_next     = run_reg;
        flag_next    = flag_reg;
        mode_next    = mode_reg;
        cand_next    = cand_reg;
        left_next    = left_reg;
        before_next  = before_reg;
        res_sts_next = res_sts_reg;
        asg_next     = asg_reg;
        o_sts_next   = o_sts_reg;
        o_asg_next   = o_asg_reg;
        o_cur_next   = o_cur_reg;
        o_prev_next  = o_prev_reg;
        o_sw_next    = o_sw_reg;

        if (cmd.start)
        begin
            before_next  = run_reg;
            res_sts_next = STS_OK;
            asg_next     = '0;
            left_next    = '0;
            unique case (kind)
                KIND_CREATE:
                begin
                    mode_next = SCAN_CREATE;
                    cand_next = '0;
                    left_next = hw_reg;
                end
                KIND_REMOVE:
                begin
                    if (id_bad)
                    begin
                        res_sts_next = STS_BAD_ID;
                    end
                    else
                    begin
                        used_next[id_slot] = 1'b0;
                        mode_next = SCAN_NEXT_QUIET;
                        cand_next = slot_up(run_reg, hw_reg);
                        left_next = hw_reg - HW'(1);
                    end
                end
                KIND_TICK:
                begin
                    if (flag_reg)
                    begin
                        flag_next = 1'b0;
                    end
                    else
                    begin
                        mode_next = SCAN_NEXT;
                        cand_next = slot_up(run_reg, hw_reg);
                        left_next = hw_reg - HW'(1);
                    end
                end
                KIND_YIELD:
                begin
                    flag_next = 1'b1;
                    mode_next = SCAN_NEXT;
                    cand_next = slot_up(run_reg, hw_reg);
                    left_next = hw_reg - HW'(1);
                end
                KIND_PREV:
                begin
                    mode_next = SCAN_PREV;
                    cand_next = slot_dn(run_reg, hw_reg);
                    left_next = hw_reg - HW'(1);
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end

        if (cmd.step)
        begin
            if (mode_reg == SCAN_PREV)
            begin
                cand_next = slot_dn(cand_reg, hw_reg);
            end
            else
            begin
                cand_next = slot_up(cand_reg, hw_reg);
            end
            left_next = left_reg - HW'(1);
        end

        if (cmd.resolve_hit)
        begin
            if (mode_reg == SCAN_CREATE)
            begin
                used_next[cand_reg] = 1'b1;
                asg_next = cand_reg;
            end
            else
            begin
                run_next = cand_reg;
            end
        end

        if (cmd.resolve_miss)
        begin
            unique case (mode_reg)
                SCAN_CREATE:
                begin
                    if (hw_reg != HW'(MAX_TASKS))
                    begin
                        used_next[hw_reg[IW-1:0]] = 1'b1;
                        asg_next = hw_reg[IW-1:0];
                        hw_next  = hw_reg + HW'(1);
                    end
                    else
                    begin
                        res_sts_next = STS_FULL;
                    end
                end
                SCAN_NEXT_QUIET:
                begin
                    res_sts_next = STS_OK;
                end
                SCAN_NEXT, SCAN_PREV:
                begin
                    res_sts_next = STS_NO_TASK;
                end
                default:
                begin
                    res_sts_next = res_sts_reg;
                end
            endcase
        end

        if (cmd.emit)
        begin
            o_sts_next  = res_sts_reg;
            o_asg_next  = asg_ext[ID_W-1:0];
            o_cur_next  = run_ext[ID_W-1:0];
            o_prev_next = before_ext[ID_W-1:0];
            o_sw_next   = (run_reg != before_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= MAX_TASKS'(1);
            hw_reg   <= HW'(1);
            run_reg  <= '0;
            flag_reg <= 1'b0;
            mode_reg <= SCAN_CREATE;
            left_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
            hw_reg   <= hw_next;
            run_reg  <= run_next;
            flag_reg <= flag_next;
            mode_reg <= mode_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg    <= cand_next;
        before_reg  <= before_next;
        res_sts_reg <= res_sts_next;
        asg_reg     <= asg_next;
        o_sts_reg   <= o_sts_next;
        o_asg_reg   <= o_asg_next;
        o_cur_reg   <= o_cur_next;
        o_prev_reg  <= o_prev_next;
        o_sw_reg    <= o_sw_next;
    end

    assign status        = o_sts_reg;
    assign assigned_id   = o_asg_reg;
    assign current_task  = o_cur_reg;
    assign previous_task = o_prev_reg;
    assign switched      = o_sw_reg;

endmodule

FILE: rtl/core/round_robin_task_slot_scheduler.sv
`timescale 1ns / 1ps

// Round-robin task slot scheduler. One item in, one result item out. The
// item is taken, then a scan visits one slot per cycle (lowest free slot for
// create, next or previous used slot for the switching kinds), then the
// output register is loaded once it is free. No scan is needed for a bad
// remove, a suppressed tick or an unknown kind; otherwise the scan covers the
// slots below high_water, the slot table's high-water mark (slot 0 plus every
// slot ever handed out, at most MAX_TASKS). The next item is taken while a
// result still waits in the output register. Slot numbers on the ports are
// the low 5 bits of the slot.
module round_robin_task_slot_scheduler
#(
    parameter int MAX_TASKS = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rrtss_pkg::S_TDATA_W-1:0] s_tdata,  // task_id[4:0], zero[7:5]
    input  logic [rrtss_pkg::S_TUSER_W-1:0] s_tuser,  // kind[2:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], assigned_id[6:2], current_task[11:7], previous_task[16:12],
    // switched[17], zero[23:18]
    output logic [rrtss_pkg::M_TDATA_W-1:0] m_tdata
);
    import rrtss_pkg::*;

    dp_cmd_t             cmd;
    dp_sts_t             sts;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     assigned_id;
    logic [ID_W-1:0]     current_task;
    logic [ID_W-1:0]     previous_task;
    logic                switched;

    rrtss_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rrtss_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .kind          (s_tuser[KIND_W-1:0]),
        .task_id       (s_tdata[ID_W-1:0]),
        .status        (status),
        .assigned_id   (assigned_id),
        .current_task  (current_task),
        .previous_task (previous_task),
        .switched      (switched)
    );

    assign m_tdata = {6'd0, switched, previous_task, current_task, assigned_id, status};

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import rrtss_pkg::*;

    localparam int MAX_SLOTS   = 32;
    localparam int ITEMS       = 1250;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN       = 60;
    localparam int LIMIT       = 400000;

    typedef struct packed {
        logic             switched;
        logic [ID_W-1:0]  previous;
        logic [ID_W-1:0]  current;
        logic [ID_W-1:0]  assigned;
        logic [STATUS_W-1:0] status;
    } sched_result_t;

    class slot_table_tracker;
        bit              used [MAX_SLOTS];
        int              high_water;
        bit [ID_W-1:0]   running;
        bit              passed;
        sched_result_t   pending_results [$];
        int              errors;

        function new();
            foreach (used[i])
            begin
                used[i] = 1'b0;
            end
            used[0]    = 1'b1;
            high_water = 1;
            running    = '0;
            passed     = 1'b0;
            errors     = 0;
        endfunction

        // round-robin search below the high-water mark, skipping the running slot
        function bit find_slot(input bit downward, output bit [ID_W-1:0] hit);
            int k;
            int c;
            hit = '0;
            if (high_water == 0 || running >= high_water)
                return 1'b0;
            for (k = 1; k < high_water; k++)
            begin
                if (downward)
                    c = (running + high_water - k) % high_water;
                else
                    c = (running + k) % high_water;
                if (used[c])
                begin
                    hit = c[ID_W-1:0];
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_event(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id);
            sched_result_t   r;
            bit [ID_W-1:0]   hit;
            bit              done;
            int              i;
            r          = '0;
            r.previous = running;
            case (kind)
                KIND_CREATE:
                begin
                    done = 1'b0;
                    for (i = 0; i < high_water && !done; i++)
                    begin
                        if (!used[i])
                        begin
                            used[i]    = 1'b1;
                            r.assigned = i[ID_W-1:0];
                            done       = 1'b1;
                        end
                    end
                    if (!done)
                    begin
                        if (high_water < MAX_SLOTS)
                        begin
                            r.assigned       = high_water[ID_W-1:0];
                            used[high_water] = 1'b1;
                            high_water++;
                        end
                        else
                        begin
                            r.status = STS_FULL;
                        end
                    end
                end
                KIND_REMOVE:
                begin
                    if (id == 0 || id >= high_water)
                    begin
                        r.status = STS_BAD_ID;
                    end
                    else
                    begin
                        used[id] = 1'b0;
                        if (find_slot(1'b0, hit))
                            running = hit;
                    end
                end
                KIND_TICK:
                begin
                    if (passed)
                        passed = 1'b0;
                    else if (find_slot(1'b0, hit))
                        running = hit;
                    else
                        r.status = STS_NO_TASK;
                end
                KIND_YIELD:
                begin
                    passed = 1'b1;
                    if (find_slot(1'b0, hit))
                        running = hit;
                    else
                        r.status = STS_NO_TASK;
                end
                KIND_PREV:
                begin
                    if (find_slot(1'b1, hit))
                        running = hit;
                    else
                        r.status = STS_NO_TASK;
                end
                default:
                begin
                end
            endcase
            r.current  = running;
            r.switched = (running != r.previous);
            pending_results = {pending_results, r};
        endfunction

        function void compare_field(input string name, input int want, input int got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input logic [M_TDATA_W-1:0] data);
            sched_result_t got;
            sched_result_t want;
            got = sched_result_t'(data[$bits(sched_result_t)-1:0]);
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual %h", $time, data);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("assigned_id", want.assigned, got.assigned);
            compare_field("current_task", want.current, got.current);
            compare_field("previous_task", want.previous, got.previous);
            compare_field("switched", want.switched, got.switched);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;

    logic                   steady;
    logic                   hold_req;
    logic                   hold_off;
    int                     cycle_count;
    slot_table_tracker      tracker;

    round_robin_task_slot_scheduler #(
        .MAX_TASKS (MAX_SLOTS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
        end
    end

    initial
    begin
        wait (cycle_count >= LIMIT);
        $display("[round_robin_task_slot_scheduler] ERROR");
        $finish;
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id);
        while (!steady && $urandom_range(0, 99) < 22)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W - ID_W){1'b0}}, id};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_event(kind, id);
    endtask

    // result side: check at the edge, then pick the next tready
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata);
            if (hold_off)
                m_tready <= 1'b0;
            else if (steady)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 22);
        end
    end

    // long back-pressure stretch so the block fills up and stalls its input
    initial
    begin
        hold_off = 1'b0;
        wait (hold_req);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        int                  n;
        int                  create_bias;
        int                  r;
        logic [KIND_W-1:0]   kind;
        logic [ID_W-1:0]     id;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        steady   = 1'b0;
        hold_req = 1'b0;
        tracker  = new();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items; while the task runs alone, every switch has nowhere to go
        send_item(KIND_TICK, 5'd0);
        send_item(KIND_YIELD, 5'd0);
        send_item(KIND_TICK, 5'd0);
        send_item(KIND_PREV, 5'd0);
        send_item(KIND_REMOVE, 5'd0);
        send_item(KIND_REMOVE, 5'd31);
        send_item(KIND_CREATE, 5'd31);
        send_item(KIND_CREATE, 5'd0);
        send_item(KIND_CREATE, 5'd0);
        send_item(KIND_TICK, 5'd0);
        send_item(KIND_YIELD, 5'd0);
        send_item(KIND_TICK, 5'd0);
        send_item(KIND_TICK, 5'd0);
        send_item(KIND_PREV, 5'd0);
        send_item(KIND_REMOVE, 5'd2);
        send_item(KIND_REMOVE, 5'd2);
        send_item(KIND_CREATE, 5'd0);
        send_item(KIND_PREV + 3'd1, 5'd31);
        send_item({KIND_W{1'b1}}, 5'd21);
        send_item(KIND_REMOVE, 5'd1);
        send_item(KIND_REMOVE, 5'd2);
        send_item(KIND_REMOVE, 5'd3);
        send_item(KIND_TICK, 5'd10);
        send_item(KIND_PREV, 5'd0);

        create_bias = 35;
        for (n = 0; n < ITEMS; n++)
        begin
            if (n % 50 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: create_bias = 8;
                    1: create_bias = 35;
                    2: create_bias = 65;
                    default: create_bias = 90;
                endcase
            end
            if (n == 300)
                hold_req <= 1'b1;
            steady <= (n >= 600 && n < 800);

            id = ID_W'($urandom_range(0, (1 << ID_W) - 1));
            if ($urandom_range(0, 99) < create_bias)
            begin
                kind = KIND_CREATE;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                begin
                    kind = KIND_REMOVE;
                    if ($urandom_range(0, 99) < 70 && tracker.high_water > 1)
                        id = ID_W'($urandom_range(1, tracker.high_water - 1));
                end
                else if (r < 60)
                    kind = KIND_TICK;
                else if (r < 75)
                    kind = KIND_YIELD;
                else if (r < 95)
                    kind = KIND_PREV;
                else
                    kind = KIND_W'($urandom_range(KIND_PREV + 1, (1 << KIND_W) - 1));
            end
            send_item(kind, id);
        end

        s_tvalid <= 1'b0;
        steady   <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (tracker.errors == 0)
            $display("[round_robin_task_slot_scheduler] OK");
        else
            $display("[round_robin_task_slot_scheduler] ERROR");
        $finish;
    end

endmodule

FILE: round_robin_task_slot_scheduler.f
rtl/core/rrtss_pkg.sv
rtl/core/rrtss_ctrl.sv
rtl/core/rrtss_datapath.sv
rtl/core/round_robin_task_slot_scheduler.sv
sim/testbench.sv
